/* rtl/core/gbpf_pkg.sv */
// Shared types and constants of the grid path finder.
`default_nettype none
package gbpf_pkg;

  localparam int unsigned GridWDefault = 16;
  localparam int unsigned GridHDefault = 16;
  localparam int unsigned WpDepth      = 256;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Marks 0..3 are arrival directions: +x, -x, +y, -y.
  localparam logic [1:0] DIR_XP = 2'd0;
  localparam logic [1:0] DIR_XN = 2'd1;
  localparam logic [1:0] DIR_YP = 2'd2;
  localparam logic [1:0] DIR_YN = 2'd3;

  localparam logic [2:0] MARK_OPEN = 3'd4;
  localparam logic [2:0] GO_A      = 3'd5;
  localparam logic [2:0] GO_B      = 3'd6;
  localparam logic [2:0] GO_BALL   = 3'd7;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_QCHK,
    ST_QEVAL,
    ST_INIT,
    ST_SETT,
    ST_SETS,
    ST_EXP_RD,
    ST_EXP_NB,
    ST_EXP_CHK,
    ST_TR_RD,
    ST_TR_CHK,
    ST_TR_END,
    ST_RD,
    ST_RDW,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic occ_we;
    logic mark_we;
  } map_we_t;

endpackage
`default_nettype wire

/* rtl/core/gbpf_map.sv */
// Occupancy map and per-query search mark memories.
`default_nettype none
module gbpf_map #(
  parameter int unsigned GRID_W = 16,
  parameter int unsigned GRID_H = 16,
  localparam int unsigned Cells = GRID_W * GRID_H,
  localparam int unsigned CW = $clog2(Cells)
) (
  input  wire logic             clk_i,
  input  wire gbpf_pkg::map_we_t we_i,
  input  wire logic [CW-1:0]    occ_waddr_i,
  input  wire logic             occ_wdata_i,
  input  wire logic [CW-1:0]    occ_raddr_i,
  output logic                  occ_rdata_o,
  input  wire logic [CW-1:0]    mark_waddr_i,
  input  wire logic [2:0]       mark_wdata_i,
  input  wire logic [CW-1:0]    mark_raddr_i,
  output logic [2:0]            mark_rdata_o
);
  import gbpf_pkg::*;

  logic       occ_mem  [Cells];
  logic [2:0] mark_mem [Cells];

  always_ff @(posedge clk_i) begin
    if (we_i.occ_we) begin
      occ_mem[occ_waddr_i] <= occ_wdata_i;
    end
    occ_rdata_o <= occ_mem[occ_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.mark_we) begin
      mark_mem[mark_waddr_i] <= mark_wdata_i;
    end
    mark_rdata_o <= mark_mem[mark_raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/core/gbpf_frontier.sv */
// Two-bank frontier memory holding the current and next search level.
`default_nettype none
module gbpf_frontier #(
  parameter int unsigned GRID_W = 16,
  parameter int unsigned GRID_H = 16,
  localparam int unsigned CW = $clog2(GRID_W * GRID_H),
  localparam int unsigned PW = $clog2(GRID_W) + $clog2(GRID_H)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [CW:0]   waddr_i,
  input  wire logic [PW-1:0] wdata_i,
  input  wire logic [CW:0]   raddr_i,
  output logic [PW-1:0]      rdata_o
);
  import gbpf_pkg::*;

  logic [PW-1:0] mem [2**(CW+1)];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/core/grid_bfs_path_finder.sv */
// Top level: request sequencer, waypoint store and result register.
//
// Grid path finder. Requests are taken one at a time, and each result can
// be held by an output stall. A path query first copies the occupancy map
// into the mark memory, then expands the search through the frontier and
// mark memories, probing each frontier cell in the four directions (an
// off-grid neighbour is skipped early), then traces back along the recorded
// arrival directions. After reset a clearing pass empties the occupancy map
// before the first request is taken.
`default_nettype none
module grid_bfs_path_finder #(
  parameter int unsigned GRID_W = gbpf_pkg::GridWDefault,
  parameter int unsigned GRID_H = gbpf_pkg::GridHDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] req_type_i,
  input  wire logic [3:0] cell_x_i,
  input  wire logic [3:0] cell_y_i,
  input  wire logic       occupied_i,
  input  wire logic [3:0] target_x_i,
  input  wire logic [3:0] target_y_i,
  input  wire logic [7:0] wp_index_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            found_o,
  output logic [7:0]      path_length_o,
  output logic [3:0]      wp_x_o,
  output logic [3:0]      wp_y_o
);
  import gbpf_pkg::*;

  localparam int unsigned XW    = $clog2(GRID_W);
  localparam int unsigned YW    = $clog2(GRID_H);
  localparam int unsigned XC    = XW + 1;
  localparam int unsigned YC    = YW + 1;
  localparam int unsigned Cells = GRID_W * GRID_H;
  localparam int unsigned CW    = $clog2(Cells);
  localparam int unsigned NW    = CW + 1;
  localparam int unsigned PW    = XW + YW;

  state_e state_q, state_d;
  logic [NW-1:0] k_q, k_d, i_q, i_d, ncur_q, ncur_d, nn_q, nn_d;
  logic [1:0] dir_q, dir_d;
  logic bank_q, bank_d, reached_q, reached_d;
  logic [XC-1:0] sx_q, sx_d, tx_q, tx_d, px_q, px_d;
  logic [YC-1:0] sy_q, sy_d, ty_q, ty_d, py_q, py_d;
  logic [7:0] idx_q, idx_d, slen_q, slen_d;
  logic res_found_q, res_found_d;
  logic [7:0] res_len_q, res_len_d;
  logic [3:0] res_wx_q, res_wx_d, res_wy_q, res_wy_d;
  logic out_valid_q, out_valid_d;
  logic found_q;
  logic [7:0] plen_q;
  logic [3:0] wx_q, wy_q;

  map_we_t map_we;
  logic [CW-1:0] occ_waddr, occ_raddr, mark_waddr, mark_raddr;
  logic occ_wdata, occ_rdata;
  logic [2:0] mark_wdata, mark_rdata;
  logic fr_we;
  logic [CW:0] fr_waddr, fr_raddr;
  logic [PW-1:0] fr_wdata, fr_rdata;
  logic wp_we;
  logic [7:0] wp_waddr, wp_raddr, wp_wdata, wp_rdata;
  logic [7:0] wp_mem [WpDepth];

  logic accept, out_free, in_range;
  logic [CW-1:0] saddr, taddr, paddr, nb_addr;
  logic [XC-1:0] nb_x, tr_x;
  logic [YC-1:0] nb_y, tr_y;
  logic nb_oob, tr_oob, is_start, k_in_wp;
  logic [7:0] k_sat;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_range   = (32'(cell_x_i) < GRID_W) && (32'(cell_y_i) < GRID_H)
                   && (32'(target_x_i) < GRID_W) && (32'(target_y_i) < GRID_H);

  assign saddr = CW'(32'(sy_q) * GRID_W + 32'(sx_q));
  assign taddr = CW'(32'(ty_q) * GRID_W + 32'(tx_q));
  assign paddr = CW'(32'(py_q) * GRID_W + 32'(px_q));

  // Neighbour of the frontier cell just read, in the current direction.
  always_comb begin
    nb_x = XC'(fr_rdata[XW-1:0]);
    nb_y = YC'(fr_rdata[PW-1:XW]);
    case (dir_q)
      DIR_XP:  nb_x = nb_x + XC'(1);
      DIR_XN:  nb_x = nb_x - XC'(1);
      DIR_YP:  nb_y = nb_y + YC'(1);
      default: nb_y = nb_y - YC'(1);
    endcase
  end
  assign nb_oob  = (32'(nb_x) >= GRID_W) || (32'(nb_y) >= GRID_H);
  assign nb_addr = CW'(32'(nb_y) * GRID_W + 32'(nb_x));
  assign is_start = (paddr == saddr);

  // Step back against the recorded arrival direction.
  always_comb begin
    tr_x = px_q;
    tr_y = py_q;
    case (mark_rdata[1:0])
      DIR_XP:  tr_x = px_q - XC'(1);
      DIR_XN:  tr_x = px_q + XC'(1);
      DIR_YP:  tr_y = py_q - YC'(1);
      default: tr_y = py_q + YC'(1);
    endcase
  end
  assign tr_oob  = (32'(tr_x) >= GRID_W) || (32'(tr_y) >= GRID_H);
  assign k_in_wp = (32'(k_q) < WpDepth);
  assign k_sat   = (32'(k_q) > 255) ? 8'hFF : 8'(k_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR:   if (k_q == NW'(Cells - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_QUERY && in_range) state_d = ST_QCHK;
          else if (req_type_i == REQ_READ)        state_d = ST_RD;
          else                                    state_d = ST_DONE;
        end
      end
      ST_QCHK:  state_d = ST_QEVAL;
      ST_QEVAL: state_d = (occ_rdata || saddr == taddr) ? ST_DONE : ST_INIT;
      ST_INIT:  if (k_q == NW'(Cells)) state_d = ST_SETT;
      ST_SETT:  state_d = ST_SETS;
      ST_SETS:  state_d = ST_EXP_RD;
      ST_EXP_RD: begin
        if (i_q < ncur_q) begin
          state_d = ST_EXP_NB;
        end else if (dir_q == DIR_YN) begin
          if (reached_q)         state_d = ST_TR_RD;
          else if (nn_q == '0)   state_d = ST_DONE;
        end
      end
      ST_EXP_NB:  state_d = nb_oob ? ST_EXP_RD : ST_EXP_CHK;
      ST_EXP_CHK: state_d = ST_EXP_RD;
      ST_TR_RD:   state_d = ST_TR_CHK;
      ST_TR_CHK: begin
        if (mark_rdata[2] || tr_oob || k_q == NW'(Cells - 1)) state_d = ST_TR_END;
        else                                                 state_d = ST_TR_RD;
      end
      ST_TR_END: state_d = ST_DONE;
      ST_RD:     state_d = ST_RDW;
      ST_RDW:    state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    k_d = k_q; i_d = i_q; ncur_d = ncur_q; nn_d = nn_q; dir_d = dir_q;
    bank_d = bank_q; reached_d = reached_q;
    sx_d = sx_q; sy_d = sy_q; tx_d = tx_q; ty_d = ty_q; px_d = px_q; py_d = py_q;
    idx_d = idx_q; slen_d = slen_q;
    res_found_d = res_found_q; res_len_d = res_len_q;
    res_wx_d = res_wx_q; res_wy_d = res_wy_q;
    out_valid_d = out_valid_q && out_stall_i;
    map_we = '0;
    occ_waddr = k_q[CW-1:0]; occ_wdata = 1'b0; occ_raddr = k_q[CW-1:0];
    mark_waddr = paddr; mark_wdata = MARK_OPEN; mark_raddr = paddr;
    fr_we = 1'b0; fr_waddr = {~bank_q, nn_q[CW-1:0]};
    fr_wdata = {py_q[YW-1:0], px_q[XW-1:0]};
    fr_raddr = {bank_q, i_q[CW-1:0]};
    wp_we = 1'b0; wp_waddr = k_q[7:0];
    wp_wdata = {4'(py_q), 4'(px_q)};
    wp_raddr = idx_q;
    unique case (state_q)
      ST_CLR: begin
        map_we.occ_we = 1'b1;
        k_d = k_q + NW'(1);
      end
      ST_IDLE: begin
        res_found_d = 1'b0; res_len_d = '0; res_wx_d = '0; res_wy_d = '0;
        sx_d = XC'(cell_x_i); sy_d = YC'(cell_y_i);
        tx_d = XC'(target_x_i); ty_d = YC'(target_y_i);
        idx_d = wp_index_i;
        occ_waddr = CW'(32'(cell_y_i) * GRID_W + 32'(cell_x_i));
        occ_wdata = occupied_i;
        if (accept && req_type_i == REQ_WRITE && (32'(cell_x_i) < GRID_W)
            && (32'(cell_y_i) < GRID_H)) begin
          map_we.occ_we = 1'b1;
        end
        k_d = '0;
      end
      ST_QCHK: occ_raddr = taddr;
      ST_QEVAL: begin
        wp_waddr = '0;
        wp_wdata = {4'(sy_q), 4'(sx_q)};
        if (!occ_rdata && saddr == taddr) begin
          wp_we = 1'b1;
          slen_d = '0;
          res_found_d = 1'b1;
        end
      end
      ST_INIT: begin
        // Read occupancy one cell ahead of the mark write.
        mark_waddr = CW'(k_q - NW'(1));
        mark_wdata = occ_rdata ? GO_BALL : MARK_OPEN;
        map_we.mark_we = (k_q != '0);
        k_d = k_q + NW'(1);
      end
      ST_SETT: begin
        map_we.mark_we = 1'b1;
        mark_waddr = taddr;
        mark_wdata = GO_A;
        fr_we = 1'b1;
        fr_waddr = '0;
        fr_wdata = {ty_q[YW-1:0], tx_q[XW-1:0]};
        bank_d = 1'b0; ncur_d = NW'(1); nn_d = '0; i_d = '0;
        dir_d = DIR_XP; reached_d = 1'b0;
      end
      ST_SETS: begin
        map_we.mark_we = 1'b1;
        mark_waddr = saddr;
        mark_wdata = GO_B;
      end
      ST_EXP_RD: begin
        if (i_q >= ncur_q) begin
          i_d = '0;
          dir_d = dir_q + 2'd1;
          if (dir_q == DIR_YN) begin
            bank_d = ~bank_q;
            ncur_d = nn_q;
            nn_d = '0;
            px_d = sx_q;
            py_d = sy_q;
            k_d = '0;
          end
        end
      end
      ST_EXP_NB: begin
        mark_raddr = nb_addr;
        px_d = nb_x;
        py_d = nb_y;
        if (nb_oob) i_d = i_q + NW'(1);
      end
      ST_EXP_CHK: begin
        mark_waddr = paddr;
        mark_wdata = {1'b0, dir_q};
        if (mark_rdata == MARK_OPEN || is_start) begin
          map_we.mark_we = 1'b1;
          if (nn_q < NW'(Cells)) begin
            fr_we = 1'b1;
            nn_d = nn_q + NW'(1);
          end
        end
        // Drop the rest of this direction once the start cell is hit.
        if (is_start) begin
          reached_d = 1'b1;
          i_d = ncur_q;
        end else begin
          i_d = i_q + NW'(1);
        end
      end
      ST_TR_RD: mark_raddr = paddr;
      ST_TR_CHK: begin
        if (!mark_rdata[2]) begin
          wp_we = k_in_wp;
          k_d = k_q + NW'(1);
          px_d = tr_x;
          py_d = tr_y;
        end
      end
      ST_TR_END: begin
        wp_we = k_in_wp;
        slen_d = k_sat;
        res_found_d = 1'b1;
        res_len_d = k_sat;
      end
      ST_RD: res_len_d = slen_q;
      ST_RDW: begin
        if (idx_q <= slen_q) begin
          res_wx_d = wp_rdata[3:0];
          res_wy_d = wp_rdata[7:4];
        end
      end
      ST_DONE: if (out_free) out_valid_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wp_we) begin
      wp_mem[wp_waddr] <= wp_wdata;
    end
    wp_rdata <= wp_mem[wp_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      k_q         <= '0;
      i_q         <= '0;
      ncur_q      <= '0;
      nn_q        <= '0;
      dir_q       <= DIR_XP;
      bank_q      <= 1'b0;
      reached_q   <= 1'b0;
      slen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      i_q         <= i_d;
      ncur_q      <= ncur_d;
      nn_q        <= nn_d;
      dir_q       <= dir_d;
      bank_q      <= bank_d;
      reached_q   <= reached_d;
      slen_q      <= slen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q <= sx_d; sy_q <= sy_d; tx_q <= tx_d; ty_q <= ty_d;
    px_q <= px_d; py_q <= py_d; idx_q <= idx_d;
    res_found_q <= res_found_d; res_len_q <= res_len_d;
    res_wx_q <= res_wx_d; res_wy_q <= res_wy_d;
    if (state_q == ST_DONE && out_free) begin
      found_q <= res_found_q;
      plen_q  <= res_len_q;
      wx_q    <= res_wx_q;
      wy_q    <= res_wy_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign path_length_o = plen_q;
  assign wp_x_o        = wx_q;
  assign wp_y_o        = wy_q;

  gbpf_map #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_map (
    .clk_i        (clk_i),
    .we_i         (map_we),
    .occ_waddr_i  (occ_waddr),
    .occ_wdata_i  (occ_wdata),
    .occ_raddr_i  (occ_raddr),
    .occ_rdata_o  (occ_rdata),
    .mark_waddr_i (mark_waddr),
    .mark_wdata_i (mark_wdata),
    .mark_raddr_i (mark_raddr),
    .mark_rdata_o (mark_rdata)
  );

  gbpf_frontier #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_frontier (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

`ifndef ASSERT_OFF
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result raised outside completion");

  a_next_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nn_q <= NW'(Cells))
    else $error("next level overflow");

  a_frontier_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXP_NB) |-> (ncur_q != '0))
    else $error("expansion with empty level");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> in_stall_o)
    else $error("item taken during clearing pass");
`endif

endmodule
`default_nettype wire

/* tb/sv/tb_grid_bfs_path_finder.sv */
// Testbench for the grid path finder: directed and random requests, scoreboard check.
module tb_grid_bfs_path_finder;
  import gbpf_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int GW = 16;
  localparam int GH = 16;
  localparam int NCELLS = GW * GH;
  localparam int IDLE_LIMIT = 40000;

  typedef struct packed {
    logic       found;
    logic [7:0] path_length;
    logic [3:0] wp_x;
    logic [3:0] wp_y;
  } answer_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] req_type_i = REQ_WRITE;
  logic [3:0] cell_x_i = '0;
  logic [3:0] cell_y_i = '0;
  logic       occupied_i = 1'b0;
  logic [3:0] target_x_i = '0;
  logic [3:0] target_y_i = '0;
  logic [7:0] wp_index_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       found_o;
  logic [7:0] path_length_o;
  logic [3:0] wp_x_o;
  logic [3:0] wp_y_o;

  grid_bfs_path_finder u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .cell_x_i, .cell_y_i,
    .occupied_i, .target_x_i, .target_y_i, .wp_index_i, .out_valid_o, .out_stall_i,
    .found_o, .path_length_o, .wp_x_o, .wp_y_o
  );

  // Predictor state
  logic        grid_occ [NCELLS];
  logic [2:0]  search_mark [NCELLS];
  logic [7:0]  route_store [256];
  int unsigned route_len;
  bit          route_valid;

  answer_t answer_q[$];
  int      err_cnt;
  int      send_idle_pct;
  int      recv_idle_pct;
  logic    hold_request = 1'b0;
  int      hold_cnt;
  int      quiet_cycles;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int step_dx(input logic [1:0] d);
    case (d)
      DIR_XP: return 1;
      DIR_XN: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic int step_dy(input logic [1:0] d);
    case (d)
      DIR_YP: return 1;
      DIR_YN: return -1;
      default: return 0;
    endcase
  endfunction

  // Breadth-first search from the target; trace back from the start on success.
  function automatic void find_route(input int sx, input int sy, input int tx, input int ty,
                                     output logic f, output logic [7:0] len);
    int s, t, d, i, c, nx, ny, n, ncur, nn, x, y, k;
    int cur[NCELLS];
    int nxt[NCELLS];
    bit reached;
    int unsigned steps;
    logic [2:0] m;
    f = 1'b0;
    len = '0;
    s = sy * GW + sx;
    t = ty * GW + tx;
    if (grid_occ[t]) return;
    if (s == t) begin
      route_store[0] = 8'((sy << 4) | sx);
      route_len = 0;
      f = 1'b1;
      return;
    end
    for (k = 0; k < NCELLS; k++) search_mark[k] = grid_occ[k] ? GO_BALL : MARK_OPEN;
    search_mark[t] = GO_A;
    search_mark[s] = GO_B;
    cur[0] = t;
    ncur = 1;
    reached = 0;
    do begin
      nn = 0;
      for (d = 0; d < 4; d++) begin
        for (i = 0; i < ncur; i++) begin
          c = cur[i];
          nx = c % GW + step_dx(2'(d));
          ny = c / GW + step_dy(2'(d));
          if (nx < 0 || nx >= GW || ny < 0 || ny >= GH) continue;
          n = ny * GW + nx;
          if (search_mark[n] == MARK_OPEN || n == s) begin
            search_mark[n] = 3'(d);
            if (nn < NCELLS) begin
              nxt[nn] = n;
              nn++;
            end
          end
          if (n == s) begin
            reached = 1;
            break;
          end
        end
      end
      cur = nxt;
      ncur = nn;
    end while (!reached && ncur != 0);
    if (!reached) return;
    x = sx;
    y = sy;
    steps = 0;
    for (k = 0; k < NCELLS; k++) begin
      m = search_mark[y * GW + x];
      if (m > 3) break;
      if (steps < 256) route_store[steps] = 8'(((y & 15) << 4) | (x & 15));
      steps++;
      x -= step_dx(m[1:0]);
      y -= step_dy(m[1:0]);
      if (x < 0 || x >= GW || y < 0 || y >= GH) break;
    end
    if (steps < 256) route_store[steps] = 8'(((y & 15) << 4) | (x & 15));
    route_len = (steps > 255) ? 255 : steps;
    f = 1'b1;
    len = 8'(route_len);
  endfunction

  function automatic answer_t predict_answer(input logic [1:0] req, input logic [3:0] cx,
                                             input logic [3:0] cy, input logic occ,
                                             input logic [3:0] tx, input logic [3:0] ty,
                                             input logic [7:0] idx);
    answer_t a;
    logic f;
    logic [7:0] len;
    a = '0;
    case (req)
      REQ_WRITE: grid_occ[cy * GW + cx] = occ;
      REQ_QUERY: begin
        find_route(cx, cy, tx, ty, f, len);
        a.found = f;
        a.path_length = len;
        if (f) route_valid = 1;
      end
      REQ_READ: begin
        a.path_length = 8'(route_len);
        if (idx <= route_len) begin
          a.wp_x = route_store[idx][3:0];
          a.wp_y = route_store[idx][7:4];
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic send_item(input logic [1:0] req, input logic [3:0] cx, input logic [3:0] cy,
                           input logic occ, input logic [3:0] tx, input logic [3:0] ty,
                           input logic [7:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    cell_x_i <= cx;
    cell_y_i <= cy;
    occupied_i <= occ;
    target_x_i <= tx;
    target_y_i <= ty;
    wp_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    answer_q.push_back(predict_answer(req, cx, cy, occ, tx, ty, idx));
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_cnt++;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = answer_q.pop_front();
        if (found_o !== want.found) report_mismatch("found", found_o, want.found);
        if (path_length_o !== want.path_length)
          report_mismatch("path_length", path_length_o, want.path_length);
        if (wp_x_o !== want.wp_x) report_mismatch("wp_x", wp_x_o, want.wp_x);
        if (wp_y_o !== want.wp_y) report_mismatch("wp_y", wp_y_o, want.wp_y);
      end
    end
  end

  // Output stall: random, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_request) hold_cnt <= 300;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    out_stall_i <= (hold_request || hold_cnt > 1) ? 1'b1 : ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IDLE_LIMIT) begin
        $display("FAIL grid_bfs_path_finder");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_item(REQ_READ, 4'hf, 4'hf, 1'b1, 4'hf, 4'hf, 8'hff);  // no route stored yet
    send_item(REQ_NONE, 4'h5, 4'ha, 1'b1, 4'h3, 4'hc, 8'h55);
    send_item(REQ_WRITE, 4'hf, 4'hf, 1'b1, 4'h0, 4'h0, 8'h00);
    send_item(REQ_QUERY, 4'h0, 4'h0, 1'b0, 4'hf, 4'hf, 8'h00);  // target occupied
    send_item(REQ_QUERY, 4'h0, 4'h0, 1'b0, 4'h0, 4'h0, 8'h00);  // start on target
    send_item(REQ_READ, 4'h0, 4'h0, 1'b0, 4'h0, 4'h0, 8'h00);
    send_item(REQ_WRITE, 4'hf, 4'hf, 1'b0, 4'h0, 4'h0, 8'h00);
    send_item(REQ_QUERY, 4'hf, 4'hf, 1'b0, 4'h0, 4'h0, 8'h00);  // corner to corner
    send_item(REQ_READ, 4'h0, 4'h0, 1'b0, 4'h0, 4'h0, 8'd0);
    send_item(REQ_READ, 4'h0, 4'h0, 1'b0, 4'h0, 4'h0, 8'd15);
    send_item(REQ_READ, 4'h0, 4'h0, 1'b0, 4'h0, 4'h0, 8'd30);
    send_item(REQ_READ, 4'h0, 4'h0, 1'b0, 4'h0, 4'h0, 8'd31);   // beyond the path
    send_item(REQ_READ, 4'h0, 4'h0, 1'b0, 4'h0, 4'h0, 8'd255);
    // walls around the start cell, query must fail and keep the stored path
    send_item(REQ_WRITE, 4'h1, 4'h0, 1'b1, 4'h0, 4'h0, 8'h00);
    send_item(REQ_WRITE, 4'h0, 4'h1, 1'b1, 4'h0, 4'h0, 8'h00);
    send_item(REQ_QUERY, 4'h0, 4'h0, 1'b0, 4'h5, 4'h5, 8'h00);
    send_item(REQ_READ, 4'h0, 4'h0, 1'b0, 4'h0, 4'h0, 8'd30);
    send_item(REQ_WRITE, 4'h1, 4'h0, 1'b0, 4'h0, 4'h0, 8'h00);
    send_item(REQ_WRITE, 4'h0, 4'h1, 1'b0, 4'h0, 4'h0, 8'h00);
    send_item(REQ_QUERY, 4'h0, 4'hf, 1'b1, 4'hf, 4'h0, 8'hff);
  endtask

  task automatic random_item();
    int pick;
    logic [1:0] req;
    logic [3:0] cx, cy, tx, ty;
    logic [7:0] idx;
    pick = $urandom_range(99);
    cx = 4'($urandom);
    cy = 4'($urandom);
    tx = 4'($urandom);
    ty = 4'($urandom);
    idx = 8'($urandom);
    if (pick < 50) req = REQ_WRITE;
    else if (pick < 70) req = REQ_QUERY;
    else if (pick < 95) req = REQ_READ;
    else req = REQ_NONE;
    if (req == REQ_QUERY && $urandom_range(9) == 0) begin
      tx = cx;
      ty = cy;
    end
    if (req == REQ_READ) begin
      if (!route_valid) idx = 8'($urandom_range(255, 1));
      else if ($urandom_range(3) != 0) idx = 8'($urandom_range(route_len + 1));
    end
    // keep the grid about a third full
    send_item(req, cx, cy, $urandom_range(99) < 30, tx, ty, idx);
  endtask

  task automatic test_random(input int count);
    repeat (count) random_item();
  endtask

  task automatic test_backpressure();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    hold_request <= 1'b1;
    @(posedge clk_i);
    hold_request <= 1'b0;
    repeat (6) random_item();
  endtask

  initial begin
    err_cnt = 0;
    route_len = 0;
    route_valid = 0;
    hold_cnt = 0;
    quiet_cycles = 0;
    foreach (grid_occ[k]) grid_occ[k] = 1'b0;
    foreach (route_store[k]) route_store[k] = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    send_idle_pct = 21;
    recv_idle_pct = 54;
    test_random(130);
    test_backpressure();
    send_idle_pct = 54;
    recv_idle_pct = 21;
    test_random(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(130);
    in_valid_i <= 1'b0;

    wait (answer_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS grid_bfs_path_finder");
    end else begin
      $display("FAIL grid_bfs_path_finder");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/gbpf_pkg.sv
rtl/core/gbpf_map.sv
rtl/core/gbpf_frontier.sv
rtl/core/grid_bfs_path_finder.sv
tb/sv/tb_grid_bfs_path_finder.sv
